[src/dct_ii_via_fft_core_macros.svh]
// Assertion macros for the DCT core.
`ifndef DCT_II_VIA_FFT_CORE_MACROS_SVH
`define DCT_II_VIA_FFT_CORE_MACROS_SVH
`ifndef ASSERT_OFF
`define DCTF_ASSERT(lbl, ck, rn, prop) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error("dctf check failed");
`define DCTF_NEVER(lbl, ck, rn, cond) \
    lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) else $error("dctf bad state");
`else
`define DCTF_ASSERT(lbl, ck, rn, prop)
`define DCTF_NEVER(lbl, ck, rn, cond)
`endif
`endif

[src/dctf_pkg.sv]
package dctf_pkg;

    localparam int unsigned DEF_POINTS = 64;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned COEF_W     = 24;
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;
    localparam longint COEF_MAX = 64'sd4194304;

    typedef struct packed {
        logic full;
        logic nonempty;
    } dctf_qstat_t;

    function automatic longint dctf_q15(longint v);
        longint r;
        if (v < 0)
        begin
            v = 0;
        end
        r = (v + 16384) >>> 15;
        return (r > 32767) ? 64'sd32767 : r;
    endfunction

    // restoring shift-subtract quotient, used only while building constant tables
    function automatic longint unsigned dctf_udiv(longint unsigned a, longint unsigned b);
        longint unsigned q, rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[62:0], a[i]};
            if (rem >= b)
            begin
                rem  = rem - b;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Q1.15 cosine and sine of pi*j/(2n), packed {cos, sin}
    function automatic logic [31:0] dctf_twiddle(int unsigned j, int unsigned n);
        longint unsigned jj, q, r, x, ts, tc;
        longint ss, cs, bc, bs, c, s;
        logic [31:0] res;
        jj = 64'(j);
        while (jj >= 64'(4 * n))
        begin
            jj = jj - 64'(4 * n);
        end
        q = '0;
        r = jj;
        while (r >= 64'(n))
        begin
            r = r - 64'(n);
            q = q + 64'd1;
        end
        x  = dctf_udiv(r * PI_Q30 + 64'(n), 64'(2 * n));
        ts = x;
        tc = ONE_Q30;
        ss = longint'(x);
        cs = longint'(ONE_Q30);
        for (int k = 1; k <= 7; k++)
        begin
            ts = (ts * x) >> 30;
            ts = dctf_udiv((ts * x) >> 30, 64'((2 * k) * (2 * k + 1)));
            tc = (tc * x) >> 30;
            tc = dctf_udiv((tc * x) >> 30, 64'((2 * k - 1) * (2 * k)));
            if ((k & 1) == 1)
            begin
                ss = ss - longint'(ts);
                cs = cs - longint'(tc);
            end
            else
            begin
                ss = ss + longint'(ts);
                cs = cs + longint'(tc);
            end
        end
        bc = dctf_q15(cs);
        bs = dctf_q15(ss);
        case (q)
            0: begin c = bc;  s = bs;  end
            1: begin c = -bs; s = bc;  end
            2: begin c = -bc; s = -bs; end
            default: begin c = bs; s = -bc; end
        endcase
        res = {c[15:0], s[15:0]};
        return res;
    endfunction

endpackage

[src/dctf_front.sv]
module dctf_front #(
    parameter int unsigned POINTS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic signed [dctf_pkg::SAMPLE_W-1:0]   sample,
    output logic                                   wr_en,
    output logic [$clog2(POINTS):0]                wr_addr,
    output logic signed [dctf_pkg::SAMPLE_W-1:0]   wr_data,
    output logic                                   push
);
    import dctf_pkg::*;

    localparam int unsigned AW = $clog2(POINTS);

    logic [AW-1:0] cnt_reg, cnt_next;
    logic          bank_reg, bank_next;
    logic          end_blk;

    assign end_blk = (cnt_reg == AW'(POINTS - 1));
    assign wr_en   = accept;
    assign wr_addr = {bank_reg, cnt_reg};
    assign wr_data = sample;
    assign push    = accept && end_blk;

    always_comb
    begin
        cnt_next  = cnt_reg;
        bank_next = bank_reg;
        if (accept)
        begin
            if (end_blk)
            begin
                cnt_next  = '0;
                bank_next = ~bank_reg;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            bank_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            bank_reg <= bank_next;
        end
    end

endmodule

[src/dctf_queue.sv]
module dctf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  pop,
    output dctf_pkg::dctf_qstat_t qstat
);
    import dctf_pkg::*;

    // counts full sample banks, two at most
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    assign qstat.full     = (cnt_reg == 2'd2);
    assign qstat.nonempty = (cnt_reg != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

[src/dctf_back.sv]
`include "dct_ii_via_fft_core_macros.svh"
module dctf_back #(
    parameter int unsigned POINTS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wr_en,
    input  logic [$clog2(POINTS):0]                wr_addr,
    input  logic signed [dctf_pkg::SAMPLE_W-1:0]   wr_data,
    input  dctf_pkg::dctf_qstat_t                  qstat,
    output logic                                   pop,
    output logic                                   strobe,
    output logic signed [dctf_pkg::COEF_W-1:0]     coefficient,
    output logic                                   last
);
    import dctf_pkg::*;

    localparam int unsigned AW  = $clog2(POINTS);
    localparam int unsigned JW  = $clog2(4 * POINTS);
    localparam int unsigned TN  = 4 * POINTS;
    localparam int unsigned HALF = (POINTS + 1) / 2;
    localparam int unsigned ACC_W = 40;
    localparam int unsigned Y_W  = 56;

    typedef enum logic [2:0] {ST_IDLE, ST_MAC, ST_W2, ST_NEXT} state_t;

    logic signed [SAMPLE_W-1:0] mem [2**(AW+1)];
    logic signed [15:0] cos_tab [TN];
    logic signed [15:0] sin_tab [TN];

    for (genvar g = 0; g < TN; g++)
    begin : g_tw
        localparam logic [31:0] TW = dctf_twiddle(g, POINTS);
        assign cos_tab[g] = TW[31:16];
        assign sin_tab[g] = TW[15:0];
    end

    state_t state_reg;
    logic [AW-1:0] k_reg, m_reg;
    logic          issue_done_reg, p1_reg, p2_reg, rbank_reg;
    logic [JW-1:0] j_reg, step_reg;
    logic signed [SAMPLE_W-1:0] d_reg;
    logic signed [15:0] c_reg, s_reg;
    logic signed [31:0] pr_reg, pi_reg;
    logic signed [ACC_W-1:0] vr_reg, vi_reg;
    logic signed [Y_W-1:0] t1_reg;
    logic strobe_reg, last_reg, pop_reg;
    logic signed [COEF_W-1:0] coef_reg;

    logic [AW-1:0] src_idx;
    logic [JW:0]   j_sum, step_sum;
    logic signed [Y_W-1:0] y0, y1, res;
    logic signed [COEF_W-1:0] sat;

    // reordered sequence: evens ascending, then a descending run from N-1
    always_comb
    begin
        if (m_reg < AW'(HALF))
        begin
            src_idx = AW'({m_reg, 1'b0});
        end
        else
        begin
            src_idx = AW'(POINTS - 1) - AW'({m_reg - AW'(HALF), 1'b0});
        end
    end

    always_comb
    begin
        j_sum = {1'b0, j_reg} + {1'b0, step_reg};
        if (j_sum >= (JW+1)'(TN))
        begin
            j_sum = j_sum - (JW+1)'(TN);
        end
        step_sum = {1'b0, step_reg} + (JW+1)'(4);
        if (step_sum >= (JW+1)'(TN))
        begin
            step_sum = step_sum - (JW+1)'(TN);
        end
    end

    // bin 0 rounds Re V from Q.15, other bins apply the weight then round from 2^29
    assign y0 = (Y_W'(vr_reg) + Y_W'(16384)) >>> 15;
    assign y1 = (t1_reg + Y_W'(vi_reg) * Y_W'(sin_tab[JW'(k_reg)]) + (Y_W'(1) <<< 28)) >>> 29;
    assign res = (k_reg == '0) ? y0 : y1;

    always_comb
    begin
        if (res > Y_W'(COEF_MAX))
        begin
            sat = COEF_W'(COEF_MAX);
        end
        else if (res < -Y_W'(COEF_MAX))
        begin
            sat = -COEF_W'(COEF_MAX);
        end
        else
        begin
            sat = res[COEF_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        d_reg  <= mem[{rbank_reg, src_idx}];
        c_reg  <= cos_tab[j_reg];
        s_reg  <= sin_tab[j_reg];
        pr_reg <= d_reg * c_reg;
        pi_reg <= d_reg * s_reg;
        t1_reg <= Y_W'(vr_reg) * Y_W'(cos_tab[JW'(k_reg)]);
        coef_reg <= sat;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            k_reg          <= '0;
            m_reg          <= '0;
            issue_done_reg <= 1'b0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            rbank_reg      <= 1'b0;
            j_reg          <= '0;
            step_reg       <= '0;
            vr_reg         <= '0;
            vi_reg         <= '0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
            pop_reg        <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            pop_reg    <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    // queue count still includes the bank while pop is high
                    if (qstat.nonempty && !pop_reg)
                    begin
                        k_reg          <= '0;
                        step_reg       <= '0;
                        m_reg          <= '0;
                        j_reg          <= '0;
                        issue_done_reg <= 1'b0;
                        vr_reg         <= '0;
                        vi_reg         <= '0;
                        state_reg      <= ST_MAC;
                    end
                end
                ST_MAC:
                begin
                    p1_reg <= !issue_done_reg;
                    p2_reg <= p1_reg;
                    if (!issue_done_reg)
                    begin
                        j_reg <= j_sum[JW-1:0];
                        if (m_reg == AW'(POINTS - 1))
                        begin
                            issue_done_reg <= 1'b1;
                        end
                        else
                        begin
                            m_reg <= m_reg + 1'b1;
                        end
                    end
                    if (p2_reg)
                    begin
                        vr_reg <= vr_reg + ACC_W'(pr_reg);
                        vi_reg <= vi_reg - ACC_W'(pi_reg);
                    end
                    if (issue_done_reg && !p1_reg && !p2_reg)
                    begin
                        state_reg <= (k_reg == '0) ? ST_NEXT : ST_W2;
                        if (k_reg == '0)
                        begin
                            strobe_reg <= 1'b1;
                            last_reg   <= (k_reg == AW'(POINTS - 1));
                        end
                    end
                end
                ST_W2:
                begin
                    strobe_reg <= 1'b1;
                    last_reg   <= (k_reg == AW'(POINTS - 1));
                    state_reg  <= ST_NEXT;
                end
                ST_NEXT:
                begin
                    if (k_reg == AW'(POINTS - 1))
                    begin
                        pop_reg   <= 1'b1;
                        rbank_reg <= ~rbank_reg;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        k_reg          <= k_reg + 1'b1;
                        step_reg       <= step_sum[JW-1:0];
                        m_reg          <= '0;
                        j_reg          <= '0;
                        issue_done_reg <= 1'b0;
                        vr_reg         <= '0;
                        vi_reg         <= '0;
                        state_reg      <= ST_MAC;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // weighted bins need the registered t1 product, so they leave from W2
    assign pop         = pop_reg;
    assign strobe      = strobe_reg;
    assign coefficient = coef_reg;
    assign last        = last_reg;

    `DCTF_ASSERT(a_strobe_pulse, clk, rst_n, strobe |=> !strobe)
    `DCTF_ASSERT(a_last_ends, clk, rst_n, (strobe && last) |=> pop)
    `DCTF_NEVER(a_pop_empty, clk, rst_n, pop && !qstat.nonempty)

endmodule

[src/dct_ii_via_fft_core.sv]
// DCT-II core, N = POINTS samples per transaction block. Assert start with a
// sample while busy is low; samples go in index order. One block may be loaded
// while the previous one is transformed. Each coefficient is accumulated on a
// single multiply-accumulate unit (direct DFT, one term a cycle), one bin
// after another. Coefficients leave in order k = 0..N-1, each for one cycle
// with strobe high, last on the final one.
// The receiver cannot stall; strobe must be taken when it appears.
module dct_ii_via_fft_core #(
    parameter int unsigned POINTS = dctf_pkg::DEF_POINTS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [dctf_pkg::SAMPLE_W-1:0]   sample,
    output logic                                   strobe,
    output logic signed [dctf_pkg::COEF_W-1:0]     coefficient,
    output logic                                   last
);
    import dctf_pkg::*;

    // block length limited to 2..64
    localparam int unsigned NPTS = (POINTS < 2) ? 2 : ((POINTS > 64) ? 64 : POINTS);
    localparam int unsigned AW = $clog2(NPTS);

    dctf_qstat_t qstat;
    logic accept, push, pop, wr_en;
    logic [AW:0] wr_addr;
    logic signed [SAMPLE_W-1:0] wr_data;

    assign busy   = qstat.full;
    assign accept = start && !busy;

    dctf_front #(.POINTS(NPTS)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .sample(sample),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data), .push(push)
    );

    dctf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .pop(pop), .qstat(qstat)
    );

    dctf_back #(.POINTS(NPTS)) u_back (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .qstat(qstat), .pop(pop), .strobe(strobe),
        .coefficient(coefficient), .last(last)
    );

endmodule
